### rtl/core/uer_pkg.sv
// Shared types, constants and register indexes for the ultrasonic echo ranger.
package uer_pkg;

  localparam int TIMER_BITS_DEF = 20;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAN_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TO      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NO_OBST      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_RISE  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_NO_OBST  = 2'd3;

  // distance = (width * CM_MUL + CM_RND) / CM_DIV
  localparam int CM_MUL = 17;
  localparam int CM_RND = 500;
  localparam int CM_DIV = 1000;
  localparam int REM_W  = 10;

  // filter remeasure window
  localparam logic [15:0] FILT_LO = 16'd3;
  localparam logic [15:0] FILT_HI = 16'd5;

  typedef struct packed {
    logic [15:0] max_distance;
    logic        filter_enable;
    logic [15:0] clean_low_us;
    logic [15:0] pulse_high_us;
    logic [19:0] rise_timeout_us;
    logic [19:0] high_timeout_us;
    logic [19:0] no_obstacle_us;
    logic [19:0] holdoff_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_distance:    16'd400,
    filter_enable:   1'b0,
    clean_low_us:    16'd4,
    pulse_high_us:   16'd10,
    rise_timeout_us: 20'd30000,
    high_timeout_us: 20'd40000,
    no_obstacle_us:  20'd25000,
    holdoff_us:      20'd60000
  };

  typedef struct packed {
    logic load;
    logic inc;
  } acc_ctl_t;

endpackage

### rtl/core/uer_range_acc.sv
// Running width-to-centimeter quotient, kept as quotient and remainder per tick.
module uer_range_acc #(
  parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uer_pkg::acc_ctl_t      ctl,
  output logic [TIMER_BITS-1:0]  cm_raw
);
  import uer_pkg::*;

  logic [TIMER_BITS-1:0] q_r, q_nxt;
  logic [REM_W-1:0]      r_r, r_nxt;
  logic [REM_W:0]        r_sum;

  always_comb begin
    r_sum = {1'b0, r_r} + (REM_W+1)'(CM_MUL);
    q_nxt = q_r;
    r_nxt = r_r;
    if (ctl.load) begin
      // width of one: (CM_MUL + CM_RND) stays below CM_DIV
      q_nxt = '0;
      r_nxt = REM_W'(CM_MUL + CM_RND);
    end else if (ctl.inc) begin
      if (r_sum >= (REM_W+1)'(CM_DIV)) begin
        r_nxt = REM_W'(r_sum - (REM_W+1)'(CM_DIV));
        q_nxt = q_r + 1'b1;
      end else begin
        r_nxt = r_sum[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
      r_r <= REM_W'(CM_RND);
    end else begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign cm_raw = q_r;

endmodule

### rtl/core/uer_core.sv
// Trigger/echo sequencer, filter and registered result beat.
module uer_core #(
  parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uer_pkg::cfg_t          cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_start_req,
  input  logic                   in_echo_level,
  input  logic [TIMER_BITS-1:0]  cm_raw,
  output uer_pkg::acc_ctl_t      acc_ctl,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_trigger_level,
  output logic                   out_busy_res,
  output logic                   out_done_res,
  output logic [15:0]            out_distance_cm,
  output logic [1:0]             out_status
);
  import uer_pkg::*;

  localparam int CW = (TIMER_BITS > 20) ? TIMER_BITS : 20;
  localparam logic [TIMER_BITS-1:0] CMASK = {TIMER_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CLEAN = 3'd1,
    PH_PULSE = 3'd2,
    PH_RISE  = 3'd3,
    PH_HIGH  = 3'd4,
    PH_HOLD  = 3'd5
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] tick_r, tick_nxt;
  logic [TIMER_BITS-1:0] since_r, since_nxt;
  logic [TIMER_BITS-1:0] width_r, width_nxt;
  logic [15:0]           first_r, first_nxt;
  logic                  second_r, second_nxt;

  logic                  out_valid_r;
  logic                  trig_r, busy_r, done_r;
  logic [15:0]           dist_r;
  logic [1:0]            status_r;

  logic                  fire;
  logic                  trig_nxt, done_nxt;
  logic [15:0]           dist_nxt;
  logic [1:0]            status_nxt;
  logic                  fin;
  logic [15:0]           fin_x;
  logic [1:0]            fin_st;
  logic [16:0]           avg_sum;
  logic [15:0]           cm_val;
  acc_ctl_t              ctl;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    sat_inc = (v == CMASK) ? CMASK : v + 1'b1;
  endfunction

  assign fire     = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  // clamped distance from the running quotient
  always_comb begin
    if (cm_raw > TIMER_BITS'(cfg.max_distance)) begin
      cm_val = cfg.max_distance;
    end else begin
      cm_val = cm_raw[15:0];
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    since_nxt  = since_r;
    width_nxt  = width_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    trig_nxt   = 1'b0;
    done_nxt   = 1'b0;
    dist_nxt   = '0;
    status_nxt = ST_OK;
    fin        = 1'b0;
    fin_x      = '0;
    fin_st     = ST_OK;
    avg_sum    = '0;
    ctl        = '0;

    if (phase_r == PH_IDLE && in_start_req) begin
      phase_nxt  = PH_CLEAN;
      tick_nxt   = '0;
      second_nxt = 1'b0;
    end

    case (phase_nxt)
      PH_CLEAN: begin
        tick_nxt = sat_inc(tick_nxt);
        if (CW'(tick_nxt) >= CW'(cfg.clean_low_us) || tick_nxt == CMASK) begin
          phase_nxt = PH_PULSE;
          tick_nxt  = '0;
        end
      end
      PH_PULSE: begin
        trig_nxt = 1'b1;
        tick_nxt = sat_inc(tick_nxt);
        if (CW'(tick_nxt) >= CW'(cfg.pulse_high_us) || tick_nxt == CMASK) begin
          phase_nxt = PH_RISE;
          tick_nxt  = '0;
          since_nxt = '0;
        end
      end
      PH_RISE: begin
        since_nxt = sat_inc(since_r);
        if (in_echo_level) begin
          phase_nxt = PH_HIGH;
          width_nxt = TIMER_BITS'(1);
          ctl.load  = 1'b1;
        end else if (CW'(since_nxt) >= CW'(cfg.rise_timeout_us) || since_nxt == CMASK) begin
          fin    = 1'b1;
          fin_x  = 16'd1;
          fin_st = ST_NO_RISE;
        end
      end
      PH_HIGH: begin
        since_nxt = sat_inc(since_r);
        if (in_echo_level) begin
          if (CW'(width_r) >= CW'(cfg.high_timeout_us) || width_r == CMASK) begin
            fin    = 1'b1;
            fin_x  = '0;
            fin_st = ST_TOO_LONG;
          end else begin
            width_nxt = width_r + 1'b1;
            ctl.inc   = 1'b1;
          end
        end else if (CW'(width_r) > CW'(cfg.no_obstacle_us)) begin
          fin    = 1'b1;
          fin_x  = cfg.max_distance;
          fin_st = ST_NO_OBST;
        end else if (CW'(since_nxt) >= CW'(cfg.holdoff_us) || since_nxt == CMASK) begin
          fin    = 1'b1;
          fin_x  = cm_val;
          fin_st = ST_OK;
        end else begin
          phase_nxt = PH_HOLD;
        end
      end
      PH_HOLD: begin
        since_nxt = sat_inc(since_r);
        if (CW'(since_nxt) >= CW'(cfg.holdoff_us) || since_nxt == CMASK) begin
          fin    = 1'b1;
          fin_x  = cm_val;
          fin_st = ST_OK;
        end
      end
      default: begin
      end
    endcase

    if (fin) begin
      done_nxt = 1'b1;
      if (cfg.filter_enable) begin
        if (!second_r) begin
          if (fin_x == '0) begin
            fin_x = cfg.max_distance;
          end
          if (fin_x inside {[FILT_LO:FILT_HI]}) begin
            // remeasure, keep first pass
            first_nxt  = fin_x;
            second_nxt = 1'b1;
            phase_nxt  = PH_CLEAN;
            tick_nxt   = '0;
            done_nxt   = 1'b0;
          end
        end else begin
          avg_sum = {1'b0, first_r} + {1'b0, fin_x};
          fin_x   = (fin_x == '0) ? cfg.max_distance : avg_sum[16:1];
        end
      end
      if (done_nxt) begin
        phase_nxt  = PH_IDLE;
        second_nxt = 1'b0;
        dist_nxt   = fin_x;
        status_nxt = fin_st;
      end
    end
  end

  assign acc_ctl = fire ? ctl : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      since_r     <= '0;
      width_r     <= '0;
      first_r     <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        since_r     <= since_nxt;
        width_r     <= width_nxt;
        first_r     <= first_nxt;
        second_r    <= second_nxt;
        out_valid_r <= 1'b1;
        trig_r      <= trig_nxt;
        busy_r      <= (phase_nxt != PH_IDLE);
        done_r      <= done_nxt;
        dist_r      <= dist_nxt;
        status_r    <= status_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = trig_r;
  assign out_busy_res      = busy_r;
  assign out_done_res      = done_r;
  assign out_distance_cm   = dist_r;
  assign out_status        = status_r;

endmodule

### rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: register file, sequencer, range accumulator.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | start_req, echo_level (one us tick)
//   out_    | output    | out_valid / out_ready  | trigger_level, busy_res, done_res,
//           |           |                        | distance_cm, status
//   cfg_    | input     | cfg_we                 | cfg_index, cfg_data
//
// One beat in, one beat out; a new tick is taken every cycle while the result
// register is empty or being drained. Each result appears in the result register the cycle after its tick.
// Synchronous reset restores register defaults and idles the sequencer.
// A stalled result blocks the next tick only while out_ready stays low.
module ultrasonic_echo_ranger #(
  parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_start_req,
  input  logic                           in_echo_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_trigger_level,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [15:0]                    out_distance_cm,
  output logic [1:0]                     out_status
);
  import uer_pkg::*;

  cfg_t                  cfg_r;
  acc_ctl_t              acc_ctl;
  logic [TIMER_BITS-1:0] cm_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DISTANCE: cfg_r.max_distance    <= cfg_data[15:0];
        REG_FILTER_EN:    cfg_r.filter_enable   <= cfg_data[0];
        REG_CLEAN_LOW:    cfg_r.clean_low_us    <= cfg_data[15:0];
        REG_PULSE_HIGH:   cfg_r.pulse_high_us   <= cfg_data[15:0];
        REG_RISE_TO:      cfg_r.rise_timeout_us <= cfg_data[19:0];
        REG_HIGH_TO:      cfg_r.high_timeout_us <= cfg_data[19:0];
        REG_NO_OBST:      cfg_r.no_obstacle_us  <= cfg_data[19:0];
        REG_HOLDOFF:      cfg_r.holdoff_us      <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  uer_range_acc #(.TIMER_BITS(TIMER_BITS)) u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .cm_raw (cm_raw)
  );

  uer_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_req      (in_start_req),
    .in_echo_level     (in_echo_level),
    .cm_raw            (cm_raw),
    .acc_ctl           (acc_ctl),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_distance_cm   (out_distance_cm),
    .out_status        (out_status)
  );

endmodule

### rtl/core/uer_checker.sv
// Port-level assertions for the ultrasonic echo ranger, bound to the top level.
module uer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_trigger_level,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [15:0] out_distance_cm,
  input logic [1:0]  out_status
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_cm)
      && $stable(out_status) && $stable(out_done_res))
    else $error("result beat changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_distance_cm == 16'd0 && out_status == 2'd0)
    else $error("distance or status set without done");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_trigger_level)
    else $error("done beat while busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_level |-> out_busy_res)
    else $error("trigger high outside a measurement");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result register");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_trigger_level (out_trigger_level),
  .out_busy_res      (out_busy_res),
  .out_done_res      (out_done_res),
  .out_distance_cm   (out_distance_cm),
  .out_status        (out_status)
);
